### rtl/sparse_triplet_matrix_add_assert.svh
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_assert.svh
// assertion macros shared by the sparse triplet adder rtl
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_MATRIX_ADD_ASSERT_SVH
`define SPARSE_TRIPLET_MATRIX_ADD_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define STMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define STMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/stma_pkg.sv
// ----------------------------------------------------------------------------
// stma_pkg
// shared constants and codes for the sparse triplet matrix adder
// ----------------------------------------------------------------------------
package stma_pkg;

    localparam int STMA_DEPTH      = 32;
    localparam int STMA_COORD_BITS = 16;

    localparam int COORD_W   = 16;
    localparam int VAL_W     = 32;
    localparam int OUT_VAL_W = 33;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    localparam logic [1:0] SRC_A    = 2'd0;
    localparam logic [1:0] SRC_B    = 2'd1;
    localparam logic [1:0] SRC_BOTH = 2'd2;

endpackage

### rtl/sparse_triplet_matrix_add.sv
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add
// merges two row-major sparse triplet lists into their sum
// ----------------------------------------------------------------------------
// usage:
//   input stream s_axis: tuser carries the op, tdata carries row, col, value.
//   op load a / load b append one triplet to a list; a full list drops the
//   triplet and sets a sticky overflow flag.
//   op merge walks both lists from their heads and emits one result
//   transaction per merged triplet on m_axis, with tlast on the final one.
//   a merge of two empty lists emits nothing and only clears the flag.
// flow:
//   loads are taken back to back while the block is idle.
//   a merge first primes the ram read ports in S_PRIME, then emits one
//   result per cycle in S_RUN while the receiver does not stall; the
//   priming covers the registered read of the two list rams.
//   s_axis_tready is low for the whole merge.
// reset: list counts and the flag are cleared, nothing is pending.
// receiver stall: the result register holds its triplet and the merge
//   pauses on the same list heads until the transaction completes.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add
    import stma_pkg::*;
#(
    parameter int DEPTH      = STMA_DEPTH,
    parameter int COORD_BITS = STMA_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row[15:0], col[31:16], value[63:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_row[15:0], out_col[31:16], out_value[64:32], zero pad[71:65]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // source[1:0], overflowed[2]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

`include "sparse_triplet_matrix_add_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = 2 * COORD_BITS + VAL_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_drop, n_drop;

    logic                 r_out_valid, n_out_valid;
    logic [COORD_W-1:0]   r_out_row, n_out_row;
    logic [COORD_W-1:0]   r_out_col, n_out_col;
    logic [OUT_VAL_W-1:0] r_out_value, n_out_value;
    logic [1:0]           r_out_src, n_out_src;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ovf, n_out_ovf;

    logic          we_a, we_b;
    logic [MW-1:0] wdata, rd_a, rd_b;

    logic [COORD_BITS-1:0] a_row, a_col, b_row, b_col;
    logic [VAL_W-1:0]      a_val, b_val;
    logic a_left, b_left, same, a_first, take_a, take_b, out_free, fire, run_last;
    logic [CW-1:0] i_adv, j_adv;

    assign wdata = {s_axis_tdata[63:32],
                    s_axis_tdata[16 +: COORD_BITS],
                    s_axis_tdata[0 +: COORD_BITS]};

    stma_list_ram #(.DEPTH(DEPTH), .WIDTH(MW), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    stma_list_ram #(.DEPTH(DEPTH), .WIDTH(MW), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign a_row = rd_a[0 +: COORD_BITS];
    assign a_col = rd_a[COORD_BITS +: COORD_BITS];
    assign a_val = rd_a[2*COORD_BITS +: VAL_W];
    assign b_row = rd_b[0 +: COORD_BITS];
    assign b_col = rd_b[COORD_BITS +: COORD_BITS];
    assign b_val = rd_b[2*COORD_BITS +: VAL_W];

    // head selection: the smaller row-major head goes, both on a match, the other list's once one is used up
    assign a_left  = (r_i < r_cnt_a);
    assign b_left  = (r_j < r_cnt_b);
    assign same    = (a_row == b_row) && (a_col == b_col);
    assign a_first = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
    assign take_a  = a_left && (!b_left || same || a_first);
    assign take_b  = b_left && (!a_left || same || !a_first);

    // list heads after this step
    assign i_adv = r_i + CW'(take_a);
    assign j_adv = r_j + CW'(take_b);

    assign out_free = !r_out_valid || m_axis_tready;
    assign fire     = (r_state == S_RUN) && out_free;
    assign run_last = (i_adv == r_cnt_a) && (j_adv == r_cnt_b);

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_out_src   = r_out_src;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        we_a        = 1'b0;
        we_b        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        OP_LOAD_A: begin
                            if (r_cnt_a == FULL) begin
                                n_drop = 1'b1;
                            end else begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        OP_LOAD_B: begin
                            if (r_cnt_b == FULL) begin
                                n_drop = 1'b1;
                            end else begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end
                        end
                        OP_MERGE: begin
                            if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                                n_drop = 1'b0;
                            end else begin
                                n_state = S_PRIME;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PRIME: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (out_free) begin
                    n_i         = i_adv;
                    n_j         = j_adv;
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_drop;
                    n_out_last  = run_last;
                    if (take_a) begin
                        n_out_row = COORD_W'(a_row);
                        n_out_col = COORD_W'(a_col);
                    end else begin
                        n_out_row = COORD_W'(b_row);
                        n_out_col = COORD_W'(b_col);
                    end
                    if (take_a && take_b) begin
                        n_out_src   = SRC_BOTH;
                        n_out_value = {a_val[VAL_W-1], a_val} + {b_val[VAL_W-1], b_val};
                    end else if (take_a) begin
                        n_out_src   = SRC_A;
                        n_out_value = {a_val[VAL_W-1], a_val};
                    end else begin
                        n_out_src   = SRC_B;
                        n_out_value = {b_val[VAL_W-1], b_val};
                    end
                    if (run_last) begin
                        n_state = S_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // list indices restart at the heads for the next merge
        if (n_state == S_IDLE) begin
            n_i = '0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_out_src   <= n_out_src;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_VAL_W - 2*COORD_W)'(0),
                            r_out_value, r_out_col, r_out_row};
    assign m_axis_tuser  = {r_out_ovf, r_out_src};
    assign m_axis_tlast  = r_out_last;

    `STMA_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, 1'b1, r_i <= r_cnt_a)
    `STMA_ASSERT_IMPL(b_idx_in_range, i_clk, i_rst_n, 1'b1, r_j <= r_cnt_b)
    `STMA_ASSERT_IMPL(run_has_work, i_clk, i_rst_n, r_state == S_RUN, a_left || b_left)
    `STMA_ASSERT_NEXT(last_ends_run, i_clk, i_rst_n, fire && run_last, r_state == S_IDLE && m_axis_tlast && r_cnt_a == '0 && r_cnt_b == '0)

endmodule

### rtl/stma_list_ram.sv
// ----------------------------------------------------------------------------
// stma_list_ram
// single-write, single-read synchronous ram holding one triplet list
// ----------------------------------------------------------------------------
module stma_list_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sparse_triplet_matrix_add_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_checker
// watches both stream channels, keeps its own copy of the two triplet
// lists, predicts every merged triplet and compares each result transaction
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add_checker
    import stma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // row[15:0], col[31:16], value[63:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_row[15:0], out_col[31:16], out_value[64:32], zero pad[71:65]
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // source[1:0], overflowed[2]
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_merges,
    output int                    o_results,
    output int                    o_sums,
    output int                    o_flagged
);

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << STMA_COORD_BITS) - 1);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   value;
    } triplet_t;

    typedef struct packed {
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [OUT_VAL_W-1:0] value;
        logic [1:0]           source;
        logic                 last;
        logic                 overflowed;
    } merged_t;

    triplet_t list_a [STMA_DEPTH];
    triplet_t list_b [STMA_DEPTH];
    int       count_a;
    int       count_b;
    logic     drop_seen;
    merged_t  merged_q [$];

    function automatic logic [OUT_VAL_W-1:0] widen(input logic [VAL_W-1:0] v);
        return {v[VAL_W-1], v};
    endfunction

    task automatic load_triplet(input logic is_b);
        triplet_t t;
        t.row   = s_axis_tdata[15:0] & COORD_MASK;
        t.col   = s_axis_tdata[31:16] & COORD_MASK;
        t.value = s_axis_tdata[63:32];
        if (!is_b) begin
            if (count_a >= STMA_DEPTH) drop_seen = 1'b1;
            else begin
                list_a[count_a] = t;
                count_a++;
            end
        end else begin
            if (count_b >= STMA_DEPTH) drop_seen = 1'b1;
            else begin
                list_b[count_b] = t;
                count_b++;
            end
        end
    endtask

    // walk both heads in row-major order, equal heads are summed
    task automatic merge_lists();
        int      ia;
        int      ib;
        merged_t r;
        ia = 0;
        ib = 0;
        while (ia < count_a || ib < count_b) begin
            if (ia < count_a && ib < count_b &&
                {list_a[ia].row, list_a[ia].col} == {list_b[ib].row, list_b[ib].col}) begin
                r.row    = list_a[ia].row;
                r.col    = list_a[ia].col;
                r.value  = widen(list_a[ia].value) + widen(list_b[ib].value);
                r.source = SRC_BOTH;
                ia++;
                ib++;
            end else if (ib >= count_b || (ia < count_a &&
                         {list_a[ia].row, list_a[ia].col} < {list_b[ib].row, list_b[ib].col})) begin
                r.row    = list_a[ia].row;
                r.col    = list_a[ia].col;
                r.value  = widen(list_a[ia].value);
                r.source = SRC_A;
                ia++;
            end else begin
                r.row    = list_b[ib].row;
                r.col    = list_b[ib].col;
                r.value  = widen(list_b[ib].value);
                r.source = SRC_B;
                ib++;
            end
            r.last       = (ia >= count_a && ib >= count_b);
            r.overflowed = drop_seen;
            merged_q.push_back(r);
        end
        count_a   = 0;
        count_b   = 0;
        drop_seen = 1'b0;
        o_merges++;
    endtask

    task automatic check_field(input string what, input logic [OUT_VAL_W-1:0] want,
                               input logic [OUT_VAL_W-1:0] got);
        if (got !== want) begin
            $display("t=%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
            o_mismatches++;
        end
    endtask

    task automatic check_result();
        merged_t want;
        if (merged_q.size() == 0) begin
            $display("t=%0t unexpected result: expected none, actual data %h user %h last %b",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            o_mismatches++;
        end else begin
            want = merged_q.pop_front();
            check_field("out_row", OUT_VAL_W'(want.row), OUT_VAL_W'(m_axis_tdata[15:0]));
            check_field("out_col", OUT_VAL_W'(want.col), OUT_VAL_W'(m_axis_tdata[31:16]));
            check_field("out_value", want.value, m_axis_tdata[64:32]);
            check_field("pad", '0, OUT_VAL_W'(m_axis_tdata[71:65]));
            check_field("source", OUT_VAL_W'(want.source), OUT_VAL_W'(m_axis_tuser[1:0]));
            check_field("overflowed", OUT_VAL_W'(want.overflowed), OUT_VAL_W'(m_axis_tuser[2]));
            check_field("last", OUT_VAL_W'(want.last), OUT_VAL_W'(m_axis_tlast));
            if (want.source == SRC_BOTH) o_sums++;
            if (want.overflowed) o_flagged++;
        end
        o_results++;
    endtask

    // counters and lists start out cleared while reset is held
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_a      = 0;
            count_b      = 0;
            drop_seen    = 1'b0;
            o_mismatches = 0;
            o_merges     = 0;
            o_results    = 0;
            o_sums       = 0;
            o_flagged    = 0;
            merged_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_LOAD_A: load_triplet(1'b0);
                    OP_LOAD_B: load_triplet(1'b1);
                    OP_MERGE:  merge_lists();
                    default: ;
                endcase
            end
        end
        o_pending = merged_q.size();
    end

endmodule

### tb/sparse_triplet_matrix_add_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_tb
// drives load and merge transactions into the sparse triplet adder with
// bursty input and a stalling receiver; the checker predicts and compares
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add_tb;
    import stma_pkg::*;

    // op code the block ignores
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         ITEM_TARGET = 400;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   value;
    } load_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatches;
    int pending;
    int merges;
    int results;
    int sums;
    int flagged;

    int items_sent;
    int counted;
    int long_stalls;
    int burst_left;
    bit steady;

    sparse_triplet_matrix_add u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sparse_triplet_matrix_add_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_merges      (merges),
        .o_results     (results),
        .o_sums        (sums),
        .o_flagged     (flagged)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // one input transaction, with a random gap whenever a burst runs out, unless steady
    task automatic send_item(input logic [1:0] op, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            if (!steady) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, col, row};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (op != OP_IGNORED) counted++;
    endtask

    // one list-pair build followed by a merge; overfill pushes one or both
    // lists past their depth so the drop flag gets set
    task automatic run_session(input bit overfill);
        load_t       for_a [$];
        load_t       for_b [$];
        load_t       t;
        logic [32:0] key;
        int          n_keys;
        int          place;
        int          pick;
        int          i;
        bit          scrambled;
        scrambled = !overfill && ($urandom_range(0, 9) == 0);
        steady    = ($urandom_range(0, 3) == 0);
        if (overfill) n_keys = $urandom_range(33, 36);
        else if ($urandom_range(0, 4) != 0) n_keys = $urandom_range(0, 6);
        else n_keys = $urandom_range(7, 24);
        place = $urandom_range(0, 2);
        case (overfill ? 0 : $urandom_range(0, 3))
            0:       key = 33'($urandom_range(0, 15));
            1:       key = {1'b0, $urandom};
            2:       key = 33'h0_FFFF_FF00 + 33'($urandom_range(0, 255));
            default: key = 33'($urandom_range(0, 255)) << 16;
        endcase
        for (i = 0; i < n_keys; i++) begin
            // broken ordering with repeated coordinates on a tiny grid
            if (scrambled)
                key = {1'b0, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
            if (key > 33'h0_FFFF_FFFF) break;
            if (!overfill) begin
                pick  = $urandom_range(0, 4);
                place = (pick < 2) ? 0 : (pick < 4) ? 1 : 2;
            end
            t.row = key[31:16];
            t.col = key[15:0];
            if (place != 1) begin
                t.op    = OP_LOAD_A;
                t.value = rand_value();
                for_a.push_back(t);
            end
            if (place != 0) begin
                t.op    = OP_LOAD_B;
                t.value = rand_value();
                for_b.push_back(t);
            end
            case ($urandom_range(0, 7))
                0:       key += 33'h1_0000;
                1:       key += 33'($urandom_range(1, 1 << 20));
                default: key += 33'($urandom_range(1, 3));
            endcase
        end
        while (for_a.size() + for_b.size() > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_IGNORED, 16'($urandom), 16'($urandom), $urandom);
            if (for_b.size() == 0 || (for_a.size() != 0 && $urandom_range(0, 1) == 0))
                t = for_a.pop_front();
            else
                t = for_b.pop_front();
            send_item(t.op, t.row, t.col, t.value);
        end
        send_item(OP_MERGE, 16'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(0, 7) == 0)
            send_item(OP_MERGE, 16'($urandom), 16'($urandom), $urandom);
    endtask

    // receiver: changing stall patterns plus a few long hold-offs while
    // results are outstanding, so the block backs up into its input
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left     = 0;
        mode          = 0;
        mode_left     = 0;
        long_stalls   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (pending > 0 && long_stalls < 4 &&
                         ((long_stalls == 0 && counted >= 30) ||
                          $urandom_range(0, 999) == 0)) begin
                hold_left = $urandom_range(150, 300);
                long_stalls++;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** sparse_triplet_matrix_add: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD_A;
        items_sent    = 0;
        counted       = 0;
        burst_left    = 0;
        steady        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty merge, then an ignored op with busy data
        send_item(OP_MERGE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_IGNORED, 16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF);
        // extreme sums, a zero sum, pass-through at the far corner
        send_item(OP_LOAD_A, 16'h0000, 16'h0000, 32'h8000_0000);
        send_item(OP_LOAD_B, 16'h0000, 16'h0000, 32'h8000_0000);
        send_item(OP_LOAD_A, 16'h0000, 16'h0001, 32'h7FFF_FFFF);
        send_item(OP_LOAD_B, 16'h0000, 16'h0001, 32'h7FFF_FFFF);
        send_item(OP_LOAD_B, 16'h0001, 16'h0000, 32'd3);
        send_item(OP_LOAD_A, 16'h0005, 16'h0005, 32'd7);
        send_item(OP_LOAD_B, 16'h0005, 16'h0005, -32'sd7);
        send_item(OP_LOAD_B, 16'hFFFF, 16'hFFFE, 32'd1);
        send_item(OP_LOAD_A, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_MERGE, 16'h0000, 16'h0000, 32'h0000_0000);
        // unsorted and repeated coordinates
        send_item(OP_LOAD_A, 16'h0003, 16'h0003, 32'd1);
        send_item(OP_LOAD_A, 16'h0001, 16'h0001, 32'd2);
        send_item(OP_LOAD_A, 16'h0003, 16'h0003, 32'd5);
        send_item(OP_LOAD_B, 16'h0002, 16'h0002, 32'd3);
        send_item(OP_LOAD_B, 16'h0003, 16'h0003, 32'd4);
        send_item(OP_MERGE, 16'h1234, 16'h5678, 32'h9ABC_DEF0);
        // one list only, each side
        send_item(OP_LOAD_A, 16'h0007, 16'h0000, 32'd1);
        send_item(OP_MERGE, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(OP_LOAD_B, 16'h0000, 16'h0007, -32'sd5);
        send_item(OP_MERGE, 16'h0000, 16'h0000, 32'h0000_0000);

        run_session(1'b1);
        while (counted < ITEM_TARGET)
            run_session($urandom_range(0, 19) == 0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("covered %0d input transactions (%0d ignored ops), %0d merges, %0d hold-offs",
                 items_sent, items_sent - counted, merges, long_stalls);
        $display("checked %0d result transactions: %0d summed, %0d carrying the drop flag",
                 results, sums, flagged);
        if (mismatches == 0)
            $display("** sparse_triplet_matrix_add: PASSED **");
        else
            $display("** sparse_triplet_matrix_add: FAILED **");
        $finish;
    end

endmodule
